/* hdl/epr_pkg.sv */
// ----------------------------------------------------------------------------
// epr_pkg
// Shared types and constants of the escaped packet receiver.
// ----------------------------------------------------------------------------
package epr_pkg;

	localparam int BYTE_W            = 8;
	localparam int LEN_W             = 5;
	localparam int MAX_PAYLOAD       = 31;
	localparam int MAX_RAW_BYTES_DEF = 32;
	localparam int CFG_IDX_W         = 2;
	localparam int OUT_DATA_W        = 32;

	localparam logic [BYTE_W-1:0] HEADER_RST  = 8'd2;
	localparam logic [BYTE_W-1:0] END_RST     = 8'd3;
	localparam logic [BYTE_W-1:0] ESCAPE_RST  = 8'd27;
	localparam logic [BYTE_W-1:0] ADDRESS_RST = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER,
		REG_END,
		REG_ESCAPE,
		REG_ADDRESS
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_DEST,
		ST_SRC,
		ST_CMD,
		ST_DATA,
		ST_EVAL,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic add_dest;
		logic load_sender;
		logic load_command;
		logic data_byte;
		logic clr_idx;
		logic rd;
		logic next;
	} cmd_t;

	typedef struct packed {
		logic eq_hdr;
		logic eq_end;
		logic eq_addr;
		logic raw_full;
		logic pkt_ok;
		logic pkt_empty;
		logic rd_last;
	} sts_t;

endpackage

/* hdl/epr_ctrl.sv */
// ----------------------------------------------------------------------------
// epr_ctrl
// Packet phase controller: steers the datapath per received beat and
// sequences the payload readout.
// ----------------------------------------------------------------------------
module epr_ctrl import epr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_HUNT: begin
				if (s_tvalid && sts.eq_hdr) begin
					state_d = ST_DEST;
				end
			end
			ST_DEST: begin
				if (s_tvalid) begin
					if (sts.eq_addr) begin
						state_d = ST_SRC;
					end else if (sts.eq_hdr) begin
						state_d = ST_DEST;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_SRC: begin
				if (s_tvalid) begin
					state_d = ST_CMD;
				end
			end
			ST_CMD: begin
				if (s_tvalid) begin
					state_d = ST_DATA;
				end
			end
			ST_DATA: begin
				if (s_tvalid) begin
					priority if (sts.eq_end) begin
						state_d = ST_EVAL;
					end else if (!sts.raw_full) begin
						state_d = ST_DATA;
					end else if (sts.eq_hdr) begin
						state_d = ST_DEST;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_EVAL: begin
				priority if (!sts.pkt_ok) begin
					state_d = ST_HUNT;
				end else if (sts.pkt_empty) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (m_tready) begin
					state_d = sts.rd_last ? ST_HUNT : ST_READ;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_HUNT: begin
				s_tready  = 1'b1;
				cmd.start = s_tvalid && sts.eq_hdr;
			end
			ST_DEST: begin
				s_tready     = 1'b1;
				cmd.add_dest = s_tvalid && sts.eq_addr;
				cmd.start    = s_tvalid && !sts.eq_addr && sts.eq_hdr;
			end
			ST_SRC: begin
				s_tready        = 1'b1;
				cmd.load_sender = s_tvalid;
			end
			ST_CMD: begin
				s_tready         = 1'b1;
				cmd.load_command = s_tvalid;
			end
			ST_DATA: begin
				s_tready      = 1'b1;
				cmd.data_byte = s_tvalid && !sts.eq_end && !sts.raw_full;
				cmd.start     = s_tvalid && !sts.eq_end && sts.raw_full && sts.eq_hdr;
			end
			ST_EVAL: begin
				cmd.clr_idx = 1'b1;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
			end
			ST_EMIT: begin
				m_tvalid = 1'b1;
				cmd.next = m_tready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* hdl/epr_dp.sv */
// ----------------------------------------------------------------------------
// epr_dp
// Receiver datapath: configuration registers, marker compares, checksum,
// unescaping, body memory and result fields.
// ----------------------------------------------------------------------------
module epr_dp import epr_pkg::*; #(
	parameter int MAX_RAW_BYTES = MAX_RAW_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic [BYTE_W-1:0]    payload_byte,
	output logic [BYTE_W-1:0]    sender,
	output logic [BYTE_W-1:0]    command,
	output logic [LEN_W-1:0]     payload_length,
	output logic                 is_last
);

	localparam int CW = $clog2(MAX_RAW_BYTES + 1);
	localparam int AW = $clog2(MAX_RAW_BYTES);

	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] end_q;
	logic [BYTE_W-1:0] escape_q;
	logic [BYTE_W-1:0] address_q;

	logic [CW-1:0]     raw_count_q;
	logic [CW-1:0]     body_count_q;
	logic [CW-1:0]     idx_q;
	logic              esc_pending_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] last_q;
	logic [BYTE_W-1:0] sender_q;
	logic [BYTE_W-1:0] command_q;
	logic [BYTE_W-1:0] rd_data_q;

	logic [BYTE_W-1:0] mem [MAX_RAW_BYTES];

	logic [BYTE_W-1:0] keep_val;
	logic              keep;
	logic              store;
	logic [CW-1:0]     plen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= HEADER_RST;
			end_q     <= END_RST;
			escape_q  <= ESCAPE_RST;
			address_q <= ADDRESS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HEADER:  header_q  <= cfg_data;
				REG_END:     end_q     <= cfg_data;
				REG_ESCAPE:  escape_q  <= cfg_data;
				REG_ADDRESS: address_q <= cfg_data;
				default:     header_q  <= header_q;
			endcase
		end
	end

	assign keep_val = esc_pending_q ? ~rx_byte : rx_byte;
	assign keep     = cmd.data_byte && (esc_pending_q || (rx_byte != escape_q));
	assign store    = keep && (body_count_q < CW'(MAX_RAW_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_count_q   <= '0;
			body_count_q  <= '0;
			idx_q         <= '0;
			esc_pending_q <= 1'b0;
			sum_q         <= '0;
			last_q        <= '0;
			sender_q      <= '0;
			command_q     <= '0;
		end else begin
			if (cmd.start) begin
				sum_q         <= rx_byte;
				raw_count_q   <= '0;
				body_count_q  <= '0;
				esc_pending_q <= 1'b0;
			end
			if (cmd.add_dest) begin
				sum_q <= sum_q + rx_byte;
			end
			if (cmd.load_sender) begin
				sender_q <= rx_byte;
				sum_q    <= sum_q + rx_byte;
			end
			if (cmd.load_command) begin
				command_q <= rx_byte;
				sum_q     <= sum_q + rx_byte;
			end
			if (cmd.data_byte) begin
				raw_count_q   <= raw_count_q + CW'(1);
				esc_pending_q <= !esc_pending_q && (rx_byte == escape_q);
			end
			if (keep) begin
				sum_q <= sum_q + keep_val;
			end
			if (store) begin
				body_count_q <= body_count_q + CW'(1);
				last_q       <= keep_val;
			end
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end
			if (cmd.next) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			mem[body_count_q[AW-1:0]] <= keep_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= mem[idx_q[AW-1:0]];
		end
	end

	assign plen = body_count_q - CW'(1);

	always_comb begin
		sts.eq_hdr    = (rx_byte == header_q);
		sts.eq_end    = (rx_byte == end_q);
		sts.eq_addr   = (rx_byte == address_q);
		sts.raw_full  = (raw_count_q == CW'(MAX_RAW_BYTES));
		sts.pkt_empty = (body_count_q == CW'(1));
		sts.pkt_ok    = (raw_count_q != '0) && !esc_pending_q && (body_count_q != '0)
			&& (32'(body_count_q) <= 32'(MAX_PAYLOAD + 1))
			&& ((sum_q - last_q) == last_q);
		sts.rd_last   = sts.pkt_empty
			|| (({1'b0, idx_q} + (CW + 1)'(2)) == {1'b0, body_count_q});
	end

	assign payload_byte   = sts.pkt_empty ? '0 : rd_data_q;
	assign sender         = sender_q;
	assign command        = command_q;
	assign payload_length = LEN_W'(plen);
	assign is_last        = sts.rd_last;

endmodule

/* hdl/escaped_packet_receiver_unit.sv */
// After its end byte is taken, a good packet passes the evaluation and read states before
// its first beat is offered; an empty payload skips the read state; a rejected packet
// returns from evaluation to hunting. Throughput: one received byte per cycle while parsing;
// in readout each result is first registered from the body memory, then held until taken.
// No byte is taken during checksum evaluation and payload readout.
// Reset (arst_n low) returns phase, counters and marker registers to their defaults at once.
// ----------------------------------------------------------------------------
// escaped_packet_receiver_unit
// Receives framed, escaped packets byte by byte and streams the payload of
// each good packet addressed to this unit.
// ----------------------------------------------------------------------------
module escaped_packet_receiver_unit import epr_pkg::*; #(
	parameter int MAX_RAW_BYTES = MAX_RAW_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] payload_byte, [15:8] sender,
	                                         // [23:16] command, [28:24] payload_length
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BYTE_W-1:0]     cfg_data
);

	cmd_t              cmd;
	sts_t              sts;
	logic [BYTE_W-1:0] payload_byte;
	logic [BYTE_W-1:0] sender;
	logic [BYTE_W-1:0] command;
	logic [LEN_W-1:0]  payload_length;

	epr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	epr_dp #(
		.MAX_RAW_BYTES (MAX_RAW_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_byte        (s_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.sts            (sts),
		.payload_byte   (payload_byte),
		.sender         (sender),
		.command        (command),
		.payload_length (payload_length),
		.is_last        (m_tlast)
	);

	assign cfg_ready = 1'b1;
	assign m_tdata   = {(OUT_DATA_W - 3 * BYTE_W - LEN_W)'(0), payload_length, command,
		sender, payload_byte};

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("Input and output beats overlap.");

	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("Receiver did not resume after the final beat.");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[28:24] == '0) |-> m_tlast && (m_tdata[7:0] == '0))
		else $error("Empty payload beat is not a single zero beat.");

endmodule
